[rtl/core/trinorm_pkg.sv]
// types, widths and step functions for the triangle unit normal pipeline
package trinorm_pkg;

	localparam int unsigned EdgeW   = 33;
	localparam int unsigned ProdW   = 2 * EdgeW;
	localparam int unsigned MagW    = ProdW;
	localparam int unsigned ShW     = 6;
	localparam int unsigned BlW     = 7;
	localparam int unsigned MW      = 31;
	localparam int unsigned SqW     = 2 * MW;
	localparam int unsigned SumW    = 64;
	localparam int unsigned LenW    = 32;
	localparam int unsigned FracW   = 14;
	localparam int unsigned QW      = FracW + 1;
	localparam int unsigned RemW    = MW + FracW + 1;
	localparam int unsigned OutW    = 16;
	localparam int unsigned IsqSteps  = SumW / 2;
	localparam int unsigned IsqStages = IsqSteps / 2;
	localparam int unsigned DivStages = (QW + 1) / 2;

	typedef struct packed {
		logic [SumW-1:0]        v;
		logic [SumW-1:0]        r;
		logic [2:0][MW-1:0]     m;
		logic [2:0]             neg;
		logic                   degen;
	} isq_t;

	typedef struct packed {
		logic [LenW-1:0]        len;
		logic [2:0][RemW-1:0]   rem;
		logic [2:0][QW-1:0]     q;
		logic [2:0]             neg;
		logic                   degen;
	} div_t;

	// one digit of the square root recurrence
	function automatic isq_t isq_step(input isq_t a, input logic [ShW-1:0] pos);
		isq_t           res;
		logic [SumW-1:0] bitv;
		logic [SumW-1:0] trial;
		res   = a;
		bitv  = SumW'(1) << pos;
		trial = a.r + bitv;
		if (a.v >= trial) begin
			res.v = a.v - trial;
			res.r = (a.r >> 1) + bitv;
		end else begin
			res.r = a.r >> 1;
		end
		return res;
	endfunction

	// one quotient bit for all three lanes
	function automatic div_t div_step(input div_t a, input logic [3:0] j);
		div_t            res;
		logic [RemW-1:0] d;
		res = a;
		d   = RemW'(a.len) << j;
		for (int i = 0; i < 3; i++) begin
			if (a.rem[i] >= d) begin
				res.rem[i]  = a.rem[i] - d;
				res.q[i][j] = 1'b1;
			end
		end
		return res;
	endfunction

endpackage

[rtl/core/triangle_unit_normal_top.sv]
// triangle unit normal: edges, cross product, normalise to signed Q1.14
//
//  channel | signals                              | dir | transfer
//  --------+--------------------------------------+-----+----------------------
//  in      | in_valid in_ready a_* b_* c_*         | in  | in_valid && in_ready
//  out     | out_valid out_ready norm_* degenerate | out | out_valid && out_ready
//
// one triangle per cycle while the output is not stalled; the pipeline holds the 16-stage square root
// (two digits a stage) and the 8-stage divider (two quotient bits a stage, one in the last)
// arst_n clears every stage valid bit; payload registers are not reset
// a stall at the output holds the whole pipeline, nothing is lost or repeated
module triangle_unit_normal_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic signed [31:0] c_x,
	input  logic signed [31:0] c_y,
	input  logic signed [31:0] c_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic               degenerate
);

	logic en;
	assign en       = out_ready || !out_valid;
	assign in_ready = en;

	// stage 1: edges
	logic v_s1;
	logic signed [trinorm_pkg::EdgeW-1:0] d1x_s1, d1y_s1, d1z_s1, d2x_s1, d2y_s1, d2z_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			d1x_s1 <= {a_x[31], a_x} - {c_x[31], c_x};
			d1y_s1 <= {a_y[31], a_y} - {c_y[31], c_y};
			d1z_s1 <= {a_z[31], a_z} - {c_z[31], c_z};
			d2x_s1 <= {b_x[31], b_x} - {c_x[31], c_x};
			d2y_s1 <= {b_y[31], b_y} - {c_y[31], c_y};
			d2z_s1 <= {b_z[31], b_z} - {c_z[31], c_z};
		end
	end

	// stage 2: six products
	logic v_s2;
	logic signed [trinorm_pkg::ProdW-1:0] p_s2 [6];

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= d1y_s1 * d2z_s1;
			p_s2[1] <= d1z_s1 * d2y_s1;
			p_s2[2] <= d1z_s1 * d2x_s1;
			p_s2[3] <= d1x_s1 * d2z_s1;
			p_s2[4] <= d1x_s1 * d2y_s1;
			p_s2[5] <= d1y_s1 * d2x_s1;
		end
	end

	// stage 3: cross components as sign and magnitude
	logic v_s3;
	logic [2:0][trinorm_pkg::MagW-1:0] mag_s3;
	logic [2:0]                        neg_s3;
	logic signed [trinorm_pkg::ProdW:0] cr [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cr[i] = {p_s2[2*i][trinorm_pkg::ProdW-1], p_s2[2*i]}
				- {p_s2[2*i+1][trinorm_pkg::ProdW-1], p_s2[2*i+1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s3[i] <= cr[i][trinorm_pkg::ProdW];
				mag_s3[i] <= cr[i][trinorm_pkg::ProdW] ?
					trinorm_pkg::MagW'(-cr[i]) : trinorm_pkg::MagW'(cr[i]);
			end
		end
	end

	// stage 4: leading one of the largest magnitude
	logic v_s4;
	logic [2:0][trinorm_pkg::MagW-1:0] mag_s4;
	logic [2:0]                        neg_s4;
	logic [trinorm_pkg::ShW-1:0]       sh_s4;
	logic                              degen_s4;
	logic [trinorm_pkg::MagW-1:0]      orv;
	logic [trinorm_pkg::BlW-1:0]       bl;

	always_comb begin
		orv = mag_s3[0] | mag_s3[1] | mag_s3[2];
		bl  = '0;
		for (int b = 0; b < trinorm_pkg::MagW; b++) begin
			if (orv[b]) bl = trinorm_pkg::BlW'(b + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s4   <= mag_s3;
			neg_s4   <= neg_s3;
			degen_s4 <= (bl == '0);
			sh_s4    <= (bl > trinorm_pkg::BlW'(trinorm_pkg::MW)) ?
				trinorm_pkg::ShW'(bl - trinorm_pkg::BlW'(trinorm_pkg::MW)) : '0;
		end
	end

	// stage 5: scale into 31 bits
	logic v_s5;
	logic [2:0][trinorm_pkg::MW-1:0] m_s5;
	logic [2:0]                      neg_s5;
	logic                            degen_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				m_s5[i] <= trinorm_pkg::MW'(mag_s4[i] >> sh_s4);
			end
			neg_s5   <= neg_s4;
			degen_s5 <= degen_s4;
		end
	end

	// stage 6: squares
	logic v_s6;
	logic [2:0][trinorm_pkg::MW-1:0]  m_s6;
	logic [2:0][trinorm_pkg::SqW-1:0] sq_s6;
	logic [2:0]                       neg_s6;
	logic                             degen_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= m_s5[i] * m_s5[i];
			end
			m_s6     <= m_s5;
			neg_s6   <= neg_s5;
			degen_s6 <= degen_s5;
		end
	end

	// stage 7: sum of squares, seeds the root
	logic v_s7;
	trinorm_pkg::isq_t isq_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			isq_s7.v     <= trinorm_pkg::SumW'(sq_s6[0]) + trinorm_pkg::SumW'(sq_s6[1])
				+ trinorm_pkg::SumW'(sq_s6[2]);
			isq_s7.r     <= '0;
			isq_s7.m     <= m_s6;
			isq_s7.neg   <= neg_s6;
			isq_s7.degen <= degen_s6;
		end
	end

	// square root stages, two digits each
	logic              isq_v_s [trinorm_pkg::IsqStages];
	trinorm_pkg::isq_t isq_s   [trinorm_pkg::IsqStages];

	for (genvar k = 0; k < trinorm_pkg::IsqStages; k++) begin : g_isq
		trinorm_pkg::isq_t prev;
		trinorm_pkg::isq_t nxt;
		if (k == 0) begin : g_first
			assign prev = isq_s7;
		end else begin : g_next
			assign prev = isq_s[k-1];
		end
		assign nxt = trinorm_pkg::isq_step(
			trinorm_pkg::isq_step(prev, trinorm_pkg::ShW'(62 - 4*k)),
			trinorm_pkg::ShW'(60 - 4*k));
		always_ff @(posedge clk) begin
			if (en) isq_s[k] <= nxt;
		end
	end

	// divider seed: rounding offset of half the length
	logic              dv_v_s [trinorm_pkg::DivStages+1];
	trinorm_pkg::div_t dv_s   [trinorm_pkg::DivStages+1];
	trinorm_pkg::isq_t isq_last;
	logic [trinorm_pkg::LenW-1:0] len;

	assign isq_last = isq_s[trinorm_pkg::IsqStages-1];
	assign len      = isq_last.r[trinorm_pkg::LenW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].len <= len;
			for (int i = 0; i < 3; i++) begin
				dv_s[0].rem[i] <= {1'b0, isq_last.m[i], trinorm_pkg::FracW'(0)}
					+ trinorm_pkg::RemW'(len >> 1);
			end
			dv_s[0].q     <= '0;
			dv_s[0].neg   <= isq_last.neg;
			dv_s[0].degen <= isq_last.degen;
		end
	end

	// divider stages, two quotient bits each, one in the last
	for (genvar k = 0; k < trinorm_pkg::DivStages; k++) begin : g_div
		trinorm_pkg::div_t nxt;
		if (2*k + 1 < trinorm_pkg::QW) begin : g_two
			assign nxt = trinorm_pkg::div_step(
				trinorm_pkg::div_step(dv_s[k], 4'(trinorm_pkg::QW - 1 - 2*k)),
				4'(trinorm_pkg::QW - 2 - 2*k));
		end else begin : g_one
			assign nxt = trinorm_pkg::div_step(dv_s[k], 4'(trinorm_pkg::QW - 1 - 2*k));
		end
		always_ff @(posedge clk) begin
			if (en) dv_s[k+1] <= nxt;
		end
	end

	// output register
	trinorm_pkg::div_t dv_last;
	logic signed [trinorm_pkg::OutW-1:0] nrm [3];

	assign dv_last = dv_s[trinorm_pkg::DivStages];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv_last.degen) begin
				nrm[i] = '0;
			end else if (dv_last.neg[i]) begin
				nrm[i] = -$signed({1'b0, dv_last.q[i]});
			end else begin
				nrm[i] = $signed({1'b0, dv_last.q[i]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_x     <= nrm[0];
			norm_y     <= nrm[1];
			norm_z     <= nrm[2];
			degenerate <= dv_last.degen;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int k = 0; k < trinorm_pkg::IsqStages; k++) isq_v_s[k] <= 1'b0;
			for (int k = 0; k <= trinorm_pkg::DivStages; k++) dv_v_s[k] <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			isq_v_s[0] <= v_s7;
			for (int k = 1; k < trinorm_pkg::IsqStages; k++) isq_v_s[k] <= isq_v_s[k-1];
			dv_v_s[0] <= isq_v_s[trinorm_pkg::IsqStages-1];
			for (int k = 1; k <= trinorm_pkg::DivStages; k++) dv_v_s[k] <= dv_v_s[k-1];
			out_valid <= dv_v_s[trinorm_pkg::DivStages];
		end
	end

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |-> (norm_x == 0 && norm_y == 0 && norm_z == 0))
		else $error("degenerate result with nonzero normal");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (norm_x <= 16384 && norm_x >= -16384 && norm_y <= 16384
			&& norm_y >= -16384 && norm_z <= 16384 && norm_z >= -16384))
		else $error("normal component out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(norm_x) && $stable(degenerate)))
		else $error("stalled result changed");

endmodule

[tb/triangle_unit_normal_checker.sv]
// checker for the triangle unit normal block: predicts normals and compares transfers
`timescale 1ns / 100ps

module triangle_unit_normal_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic signed [31:0] c_x,
	input  logic signed [31:0] c_y,
	input  logic signed [31:0] c_z,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] norm_x,
	input  logic signed [15:0] norm_y,
	input  logic signed [15:0] norm_z,
	input  logic               degenerate,
	output int                 fail_count,
	output int                 pending_normals
);

	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic               degen;
	} normal_t;

	normal_t normal_q[$];

	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic normal_t face_normal(input logic signed [31:0] ax, ay, az,
			bx, by, bz, cx, cy, cz);
		logic signed [32:0] d1x, d1y, d1z, d2x, d2y, d2z;
		logic signed [67:0] cr [3];
		logic [67:0]        mag [3];
		logic [63:0]        m [3];
		logic [63:0]        sum, len, q;
		logic [15:0]        o [3];
		int                 bits, s;
		normal_t            res;
		d1x = 33'(ax) - 33'(cx); d1y = 33'(ay) - 33'(cy); d1z = 33'(az) - 33'(cz);
		d2x = 33'(bx) - 33'(cx); d2y = 33'(by) - 33'(cy); d2z = 33'(bz) - 33'(cz);
		cr[0] = 68'(d1y) * 68'(d2z) - 68'(d1z) * 68'(d2y);
		cr[1] = 68'(d1z) * 68'(d2x) - 68'(d1x) * 68'(d2z);
		cr[2] = 68'(d1x) * 68'(d2y) - 68'(d1y) * 68'(d2x);
		bits = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = cr[i] < 0 ? 68'(-cr[i]) : 68'(cr[i]);
			for (int k = 0; k < 68; k++) if (mag[i][k] && k + 1 > bits) bits = k + 1;
		end
		if (bits == 0) return '{16'sd0, 16'sd0, 16'sd0, 1'b1};
		s = bits > 31 ? bits - 31 : 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = 64'(mag[i] >> s);
			sum += m[i] * m[i];
		end
		len = root64(sum);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * 64'd16384 + (len >> 1)) / len;
			if (q > 64'd16384) q = 64'd16384;
			o[i] = cr[i] < 0 ? 16'(-q) : 16'(q);
		end
		res.nx = o[0]; res.ny = o[1]; res.nz = o[2]; res.degen = 1'b0;
		return res;
	endfunction

	assign pending_normals = normal_q.size();

	initial fail_count = 0;

	always @(posedge clk) begin
		normal_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				normal_q.push_back(face_normal(a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z));
			if (out_valid && out_ready) begin
				if (normal_q.size() == 0) begin
					$error("result transfer with no triangle outstanding");
					fail_count++;
				end else begin
					want = normal_q.pop_front();
					if (norm_x !== want.nx) begin
						$error("norm_x expected %0d got %0d", want.nx, norm_x);
						fail_count++;
					end
					if (norm_y !== want.ny) begin
						$error("norm_y expected %0d got %0d", want.ny, norm_y);
						fail_count++;
					end
					if (norm_z !== want.nz) begin
						$error("norm_z expected %0d got %0d", want.nz, norm_z);
						fail_count++;
					end
					if (degenerate !== want.degen) begin
						$error("degenerate expected %0b got %0b", want.degen, degenerate);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

[tb/triangle_unit_normal_top_tb.sv]
// testbench top for the triangle unit normal block: stimulus and verdict
`timescale 1ns / 100ps

module triangle_unit_normal_top_tb;

	localparam int RandomFaces = 1250;
	localparam int CycleLimit  = 200000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] norm_x, norm_y, norm_z;
	logic               degenerate;
	int                 fail_count;
	int                 pending_normals;
	int                 cycle_count;
	logic               calm_stretch;

	triangle_unit_normal_top DUT (.*);

	triangle_unit_normal_checker u_checker (.*);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("[triangle_unit_normal_top] ERROR");
			$finish;
		end
	end

	// receiver stalls, except during the calm stretch
	always @(posedge clk)
		out_ready <= calm_stretch || ($urandom_range(99) >= 17);

	function automatic logic [31:0] coord_value(input int mode);
		case (mode)
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(255) - 128;
			3: return ($urandom_range(4095) - 2048) << 12;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_face(input logic [31:0] v [9]);
		a_x <= v[0]; a_y <= v[1]; a_z <= v[2];
		b_x <= v[3]; b_y <= v[4]; b_z <= v[5];
		c_x <= v[6]; c_y <= v[7]; c_z <= v[8];
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		// sender gap, skipped in the calm stretch
		if (!calm_stretch && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 40);
		end
	endtask

	initial begin
		logic [31:0] v [9];
		int mode;
		cycle_count = 0;
		calm_stretch = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, axis faces, degenerate and collinear faces
		for (int t = 0; t < 20; t++) begin
			for (int k = 0; k < 9; k++) begin
				case (t)
					0: v[k] = 32'h8000_0000;
					1: v[k] = 32'h7fff_ffff;
					2: v[k] = (k % 3 == 0) ? 32'h7fff_ffff : 32'h8000_0000;
					3: v[k] = (k < 6 && k % 4 == 0) ? 32'h0001_0000 : 32'h0;
					4: v[k] = (k == 0 || k == 4) ? 32'h7fff_ffff : 32'h8000_0000;
					5: v[k] = (k == 1 || k == 5) ? 32'h7fff_ffff : 32'h8000_0000;
					6: v[k] = (k == 2 || k == 3) ? 32'h7fff_ffff : 32'h8000_0000;
					7: v[k] = (k == 0 || k == 4) ? 32'h8000_0000 : 32'h7fff_ffff;
					8: v[k] = (k == 0 || k == 4) ? 32'h1 : 32'h0;
					9: v[k] = (k < 3) ? 32'h2 * (k + 1) : (k < 6) ? 32'h1 * (k - 2) : 32'h0;
					10: v[k] = (k < 3) ? 32'h8000_0000 : 32'h7fff_ffff;
					11: v[k] = (k % 4 == 0) ? 32'hffff_ffff : 32'h1;
					default: v[k] = coord_value(t % 5);
				endcase
			end
			send_face(v);
		end
		// random: mostly mixed magnitudes, some collinear faces
		for (int n = 0; n < RandomFaces; n++) begin
			calm_stretch = (n >= 500 && n < 700);
			mode = $urandom_range(4);
			for (int k = 0; k < 9; k++) v[k] = coord_value($urandom_range(9) < 7 ? mode : 4);
			if ($urandom_range(19) == 0)
				for (int k = 3; k < 6; k++) v[k] = v[k - 3];
			send_face(v);
		end
		in_valid <= 1'b0;
		calm_stretch = 1'b0;
		while (pending_normals != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("[triangle_unit_normal_top] OK");
		else
			$display("[triangle_unit_normal_top] ERROR");
		$finish;
	end

endmodule
